@@ rtl/upc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upc_pkg
// Types, constants and character helpers shared by the percent codec.
// ----------------------------------------------------------------------------
package upc_pkg;

  localparam int CMD_DEPTH = 4;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UC_A    = 8'h41;
  localparam logic [7:0] CH_UC_F    = 8'h46;
  localparam logic [7:0] CH_UC_Z    = 8'h5A;
  localparam logic [7:0] CH_LC_A    = 8'h61;
  localparam logic [7:0] CH_LC_F    = 8'h66;
  localparam logic [7:0] CH_LC_Z    = 8'h7A;

  localparam logic [4:0] DIGIT_BAD = 5'h1F;
  localparam logic [4:0] TEN       = 5'd10;

  localparam logic       MODE_ENCODE = 1'b0;
  localparam logic       MODE_DECODE = 1'b1;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;

  localparam logic [1:0] PART_PCT = 2'd0;
  localparam logic [1:0] PART_HI  = 2'd1;
  localparam logic [1:0] PART_LO  = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;
    logic       bad_escape;
  } out_item_t;

  // one queued job for the back end
  typedef struct packed {
    logic [7:0] data;
    logic       triple;   // expand to percent escape
    logic       last;
    logic       bad;
  } cmd_t;

  function automatic logic passes(input logic [7:0] ch);
    passes = (ch >= CH_ZERO && ch <= CH_NINE) || (ch >= CH_LC_A && ch <= CH_LC_Z) ||
             (ch >= CH_UC_A && ch <= CH_UC_Z) || ch == CH_SLASH || ch == CH_DOT;
  endfunction

  // 5-bit two's complement digit value, all ones when not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [7:0] d;
    d = 8'd0;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      d = ch - CH_ZERO;
      hex_value = d[4:0];
    end else if (ch >= CH_LC_A && ch <= CH_LC_F) begin
      d = ch - CH_LC_A;
      hex_value = d[4:0] + TEN;
    end else if (ch >= CH_UC_A && ch <= CH_UC_F) begin
      d = ch - CH_UC_A;
      hex_value = d[4:0] + TEN;
    end else begin
      hex_value = DIGIT_BAD;
    end
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      hex_char = CH_ZERO + {4'd0, nib};
    end else begin
      hex_char = CH_UC_A + {4'd0, nib} - 8'd10;
    end
  endfunction

  // hi*16 + lo mod 256, both 5-bit signed
  function automatic logic [7:0] combine(input logic [4:0] hi, input logic [4:0] lo);
    combine = {hi[3:0], 4'd0} + {{3{lo[4]}}, lo};
  endfunction

endpackage

@@ rtl/url_percent_codec.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_codec
// Streaming percent encoder / decoder for URL text.
// ----------------------------------------------------------------------------
// Input side is a queue: drive in_data and push; a word is taken when push is
// high and full is low. Results come out of a queue: while empty is low the
// oldest result sits on out_data and pop takes it.
// cfg_data selects encode (0) or decode (1); it is written when cfg_valid is
// high (cfg_ready is always high) and also clears any open escape. Write it
// only while no text is in flight.
// A pushed word is written into the job queue, then loaded into the output
// register before it shows on out_data. The front end takes one word per
// cycle while full is low; the back end sends one result per cycle while pop
// is high, so an escaped encoded byte holds the output for three results.
// Plain bytes sustain one word per cycle; the single output register slows escapes.
// A job queue of CMD_DEPTH entries sits between the two ends; when the
// receiver stops popping it fills and full rises, holding off the sender.
// Reset (synchronous, rst_n low) empties both queues, selects encode and
// drops any escape in progress.
// ----------------------------------------------------------------------------
module url_percent_codec #(
  parameter int CMD_DEPTH = upc_pkg::CMD_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  upc_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output upc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  logic          q_full, q_empty, q_wr, q_rd;
  upc_pkg::cmd_t q_wdata, q_rdata;

  upc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_wdata   (q_wdata)
  );

  upc_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wdata   (q_wdata),
    .q_full  (q_full),
    .rd      (q_rd),
    .q_empty (q_empty),
    .rdata   (q_rdata)
  );

  upc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_rdata  (q_rdata),
    .q_rd     (q_rd),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

@@ rtl/upc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upc_front
// Takes input words, tracks escape state and queues output jobs.
// ----------------------------------------------------------------------------
module upc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  upc_pkg::in_item_t in_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  input  logic              q_full,
  output logic              q_wr,
  output upc_pkg::cmd_t     q_wdata
);

  logic       mode_r, mode_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [4:0] high_r, high_nxt;
  logic       accept;
  logic       emit;
  logic [4:0] dig;

  assign full      = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = push && !q_full;
  assign dig       = upc_pkg::hex_value(in_data.in_byte);

  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    high_nxt  = high_r;
    emit      = 1'b0;
    q_wdata   = '{data: in_data.in_byte, triple: 1'b0, last: in_data.in_last, bad: 1'b0};
    if (cfg_valid) begin
      mode_nxt  = cfg_data;
      phase_nxt = upc_pkg::PH_IDLE;
      high_nxt  = 5'd0;
    end else if (accept) begin
      if (mode_r == upc_pkg::MODE_ENCODE) begin
        emit           = 1'b1;
        q_wdata.triple = !upc_pkg::passes(in_data.in_byte);
        phase_nxt      = upc_pkg::PH_IDLE;
      end else begin
        unique case (phase_r)
          upc_pkg::PH_HIGH: begin
            high_nxt  = dig;
            phase_nxt = upc_pkg::PH_LOW;
            if (in_data.in_last) begin
              emit         = 1'b1;
              q_wdata.data = upc_pkg::combine(dig, upc_pkg::DIGIT_BAD);
              q_wdata.bad  = 1'b1;
            end
          end
          upc_pkg::PH_LOW: begin
            emit         = 1'b1;
            q_wdata.data = upc_pkg::combine(high_r, dig);
            q_wdata.bad  = high_r[4] || dig[4];
            phase_nxt    = upc_pkg::PH_IDLE;
          end
          default: begin
            if (in_data.in_byte == upc_pkg::CH_PERCENT) begin
              phase_nxt = upc_pkg::PH_HIGH;
              if (in_data.in_last) begin
                emit         = 1'b1;
                q_wdata.data = upc_pkg::combine(upc_pkg::DIGIT_BAD, upc_pkg::DIGIT_BAD);
                q_wdata.bad  = 1'b1;
              end
            end else begin
              emit      = 1'b1;
              phase_nxt = upc_pkg::PH_IDLE;
            end
          end
        endcase
      end
      // end of text drops any open escape
      if (in_data.in_last) begin
        phase_nxt = upc_pkg::PH_IDLE;
        high_nxt  = 5'd0;
      end
    end
  end

  assign q_wr = accept && emit && !cfg_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= upc_pkg::MODE_ENCODE;
      phase_r <= upc_pkg::PH_IDLE;
      high_r  <= 5'd0;
    end else begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      high_r  <= high_nxt;
    end
  end

endmodule

@@ rtl/upc_cmd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upc_cmd_fifo
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module upc_cmd_fifo #(
  parameter int DEPTH = upc_pkg::CMD_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  upc_pkg::cmd_t wdata,
  output logic          q_full,
  input  logic          rd,
  output logic          q_empty,
  output upc_pkg::cmd_t rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

  upc_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign q_full  = (count_r == CNT_MAX);
  assign q_empty = (count_r == '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_MAX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_MAX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/upc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upc_back
// Expands queued jobs into result words held in an output register.
// ----------------------------------------------------------------------------
module upc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  upc_pkg::cmd_t      q_rdata,
  output logic               q_rd,
  output logic               empty,
  input  logic               pop,
  output upc_pkg::out_item_t out_data
);

  logic               out_valid_r, out_valid_nxt;
  upc_pkg::out_item_t out_r, out_nxt;
  logic [1:0]         part_r, part_nxt;
  logic               load;

  assign empty    = !out_valid_r;
  assign out_data = out_r;
  assign load     = (!out_valid_r || pop) && !q_empty;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    part_nxt      = part_r;
    q_rd          = 1'b0;
    if (load) begin
      out_valid_nxt       = 1'b1;
      out_nxt.bad_escape  = q_rdata.bad;
      if (!q_rdata.triple) begin
        out_nxt.out_byte = q_rdata.data;
        out_nxt.run_last = 1'b1;
        out_nxt.text_end = q_rdata.last;
        q_rd             = 1'b1;
      end else begin
        unique case (part_r)
          upc_pkg::PART_PCT: begin
            out_nxt.out_byte = upc_pkg::CH_PERCENT;
            out_nxt.run_last = 1'b0;
            out_nxt.text_end = 1'b0;
            part_nxt         = upc_pkg::PART_HI;
          end
          upc_pkg::PART_HI: begin
            out_nxt.out_byte = upc_pkg::hex_char(q_rdata.data[7:4]);
            out_nxt.run_last = 1'b0;
            out_nxt.text_end = 1'b0;
            part_nxt         = upc_pkg::PART_LO;
          end
          default: begin
            out_nxt.out_byte = upc_pkg::hex_char(q_rdata.data[3:0]);
            out_nxt.run_last = 1'b1;
            out_nxt.text_end = q_rdata.last;
            part_nxt         = upc_pkg::PART_PCT;
            q_rd             = 1'b1;
          end
        endcase
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      part_r      <= upc_pkg::PART_PCT;
    end else begin
      out_valid_r <= out_valid_nxt;
      part_r      <= part_nxt;
    end
  end

endmodule

@@ test/tb_url_percent_codec.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_url_percent_codec
// Self-checking bench for the URL percent encoder / decoder.
// ----------------------------------------------------------------------------
// Words are queued by a stimulus process and pushed by a clocked driver.
// Every accepted word is run through a behavioural copy of the codec, and
// the results it predicts are checked against the output queue. The bench
// covers both modes, every escape outcome, random idling on both sides and
// one long receiver stall that fills the block.
// ----------------------------------------------------------------------------
module tb_url_percent_codec;

  localparam int LIMIT       = 20000;
  localparam int SETTLE      = 10;
  localparam int HOLD_CYCLES = 150;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  upc_pkg::in_item_t  in_data = '0;
  logic               empty;
  logic               pop = 1'b0;
  upc_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data = 1'b0;

  upc_pkg::in_item_t  text_words[$];
  upc_pkg::out_item_t due_words[$];

  // behavioural copy of the codec state
  logic              cur_mode = upc_pkg::MODE_ENCODE;
  logic [1:0]        esc_phase = upc_pkg::PH_IDLE;
  logic signed [4:0] esc_hi = '0;

  int n_bad = 0;
  int cycles = 0;
  int snd_idle = 38;
  int rcv_idle = 55;
  int hold_reqs = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int words_added = 0;

  url_percent_codec u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic is_plain(input logic [7:0] ch);
    return (ch >= upc_pkg::CH_ZERO && ch <= upc_pkg::CH_NINE) ||
           (ch >= upc_pkg::CH_UC_A && ch <= upc_pkg::CH_UC_Z) ||
           (ch >= upc_pkg::CH_LC_A && ch <= upc_pkg::CH_LC_Z) ||
           ch == upc_pkg::CH_SLASH || ch == upc_pkg::CH_DOT;
  endfunction

  // -1 for anything that is not a hex digit
  function automatic int digit_val(input logic [7:0] ch);
    if (ch >= upc_pkg::CH_ZERO && ch <= upc_pkg::CH_NINE) begin
      return int'(ch - upc_pkg::CH_ZERO);
    end else if (ch >= upc_pkg::CH_UC_A && ch <= upc_pkg::CH_UC_F) begin
      return int'(ch - upc_pkg::CH_UC_A) + 10;
    end else if (ch >= upc_pkg::CH_LC_A && ch <= upc_pkg::CH_LC_F) begin
      return int'(ch - upc_pkg::CH_LC_A) + 10;
    end
    return -1;
  endfunction

  function automatic logic [7:0] nib_glyph(input logic [3:0] n);
    return (n < 4'd10) ? upc_pkg::CH_ZERO + {4'd0, n}
                       : upc_pkg::CH_UC_A - 8'd10 + {4'd0, n};
  endfunction

  function automatic logic [7:0] escape_byte(input int hi, input int lo);
    int v;
    v = hi * 16 + lo;
    return v[7:0];
  endfunction

  task automatic due_word(input logic [7:0] b, input logic rl, input logic te,
                          input logic bad);
    upc_pkg::out_item_t w;
    w.out_byte   = b;
    w.run_last   = rl;
    w.text_end   = te;
    w.bad_escape = bad;
    due_words.push_back(w);
  endtask

  task automatic convert_word(input upc_pkg::in_item_t w);
    logic [7:0] b;
    logic       lst;
    int         hi;
    int         lo;
    b   = w.in_byte;
    lst = w.in_last;
    if (cur_mode == upc_pkg::MODE_ENCODE) begin
      if (is_plain(b)) begin
        due_word(b, 1'b1, lst, 1'b0);
      end else begin
        due_word(upc_pkg::CH_PERCENT, 1'b0, 1'b0, 1'b0);
        due_word(nib_glyph(b[7:4]), 1'b0, 1'b0, 1'b0);
        due_word(nib_glyph(b[3:0]), 1'b1, lst, 1'b0);
      end
      esc_phase = upc_pkg::PH_IDLE;
    end else begin
      case (esc_phase)
        upc_pkg::PH_HIGH: begin
          hi = digit_val(b);
          esc_hi = hi[4:0];
          esc_phase = upc_pkg::PH_LOW;
          // escape cut short after the high digit
          if (lst) due_word(escape_byte(hi, -1), 1'b1, 1'b1, 1'b1);
        end
        upc_pkg::PH_LOW: begin
          hi = int'(esc_hi);
          lo = digit_val(b);
          due_word(escape_byte(hi, lo), 1'b1, lst, (hi < 0 || lo < 0));
          esc_phase = upc_pkg::PH_IDLE;
        end
        default: begin
          if (b == upc_pkg::CH_PERCENT) begin
            esc_phase = upc_pkg::PH_HIGH;
            if (lst) due_word(escape_byte(-1, -1), 1'b1, 1'b1, 1'b1);
          end else begin
            esc_phase = upc_pkg::PH_IDLE;
            due_word(b, 1'b1, lst, 1'b0);
          end
        end
      endcase
      if (lst) begin
        esc_phase = upc_pkg::PH_IDLE;
        esc_hi    = '0;
      end
    end
  endtask

  task automatic check_field(input string fld, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, fld, want_v, got_v);
      n_bad++;
    end
  endtask

  // input side: pushes queued words, tracks the codec state on every handshake
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cur_mode  = cfg_data;
        esc_phase = upc_pkg::PH_IDLE;
        esc_hi    = '0;
      end
      if (push && !full) convert_word(in_data);
      if (!push || !full) begin
        if (text_words.size() != 0 && $urandom_range(99) >= snd_idle) begin
          in_data <= text_words.pop_front();
          push    <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // output side: random pops, one long hold-off on request
  always @(posedge clk) begin : result_side
    upc_pkg::out_item_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (due_words.size() == 0) begin
          $display("%0t: word with nothing expected, expected none, actual %p", $time,
                   out_data);
          n_bad++;
        end else begin
          want = due_words.pop_front();
          check_field("out_byte", want.out_byte, out_data.out_byte);
          check_field("run_last", 8'(want.run_last), 8'(out_data.run_last));
          check_field("text_end", 8'(want.text_end), 8'(out_data.text_end));
          check_field("bad_escape", 8'(want.bad_escape), 8'(out_data.bad_escape));
        end
      end
      if (hold_taken != hold_reqs) begin
        hold_taken <= hold_reqs;
        hold_left  <= HOLD_CYCLES;
        pop        <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop       <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("url_percent_codec test failed");
      $finish;
    end
  end

  task automatic add_word(input logic [7:0] b, input logic lst);
    upc_pkg::in_item_t w;
    w.in_byte = b;
    w.in_last = lst;
    text_words.push_back(w);
    words_added++;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (text_words.size() != 0 || push || due_words.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    @(posedge clk);
    cfg_data  <= m;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] hex_glyph();
    int n;
    n = $urandom_range(15);
    if (n < 10) return upc_pkg::CH_ZERO + 8'(n);
    return ($urandom_range(1) ? upc_pkg::CH_UC_A : upc_pkg::CH_LC_A) + 8'(n - 10);
  endfunction

  function automatic logic [7:0] bad_glyph();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (digit_val(b) >= 0);
    return b;
  endfunction

  function automatic logic [7:0] plain_glyph();
    int r;
    r = $urandom_range(63);
    if (r < 10) return upc_pkg::CH_ZERO + 8'(r);
    if (r < 36) return upc_pkg::CH_UC_A + 8'(r - 10);
    if (r < 62) return upc_pkg::CH_LC_A + 8'(r - 36);
    return (r == 62) ? upc_pkg::CH_SLASH : upc_pkg::CH_DOT;
  endfunction

  // whole texts until at least n_words words are queued
  task automatic make_batch(input logic m, input int n_words);
    logic [7:0] txt[$];
    int         start;
    int         ntok;
    int         r;
    logic       cut;
    start = words_added;
    while (words_added - start < n_words) begin
      txt.delete();
      cut  = 1'b0;
      ntok = $urandom_range(1, 6);
      for (int k = 0; k < ntok && !cut; k++) begin
        r = $urandom_range(99);
        if (m == upc_pkg::MODE_ENCODE) begin
          txt.push_back(r < 50 ? plain_glyph() : 8'($urandom_range(255)));
        end else if (r < 50) begin
          txt.push_back(upc_pkg::CH_PERCENT);
          txt.push_back(hex_glyph());
          txt.push_back(hex_glyph());
        end else if (r < 72) begin
          txt.push_back(8'($urandom_range(255)));
        end else if (r < 86) begin
          // escape with one or both digits invalid
          txt.push_back(upc_pkg::CH_PERCENT);
          r = $urandom_range(2);
          txt.push_back(r == 1 ? hex_glyph() : bad_glyph());
          txt.push_back(r == 2 ? hex_glyph() : bad_glyph());
        end else begin
          // text ends inside an escape
          txt.push_back(upc_pkg::CH_PERCENT);
          if ($urandom_range(1)) txt.push_back($urandom_range(3) ? hex_glyph() : bad_glyph());
          cut = 1'b1;
        end
      end
      foreach (txt[i]) add_word(txt[i], i == txt.size() - 1);
    end
  endtask

  initial begin
    logic m;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // encode: byte extremes, range edges, symbols
    write_mode(upc_pkg::MODE_ENCODE);
    add_word(8'h00, 1'b0);
    add_word(8'hFF, 1'b0);
    add_word(upc_pkg::CH_ZERO, 1'b0);
    add_word(upc_pkg::CH_LC_Z, 1'b0);
    add_word(upc_pkg::CH_UC_A, 1'b0);
    add_word(upc_pkg::CH_SLASH, 1'b0);
    add_word(upc_pkg::CH_DOT, 1'b0);
    add_word(upc_pkg::CH_PERCENT, 1'b1);
    wait_drained();

    // decode: good escape, bad digits, zero byte, cut-short escapes
    write_mode(upc_pkg::MODE_DECODE);
    add_word(upc_pkg::CH_PERCENT, 1'b0);
    add_word(8'h34, 1'b0);
    add_word(upc_pkg::CH_LC_F, 1'b0);
    add_word(upc_pkg::CH_PERCENT, 1'b0);
    add_word(8'h47, 1'b0);
    add_word(upc_pkg::CH_LC_Z, 1'b0);
    add_word(8'h00, 1'b0);
    add_word(8'hFF, 1'b1);
    add_word(upc_pkg::CH_PERCENT, 1'b0);
    add_word(upc_pkg::CH_LC_A, 1'b1);
    add_word(upc_pkg::CH_PERCENT, 1'b1);
    add_word(upc_pkg::CH_PERCENT, 1'b0);
    wait_drained();

    // mode write drops the open escape, so 'A' passes as plain text
    write_mode(upc_pkg::MODE_DECODE);
    add_word(upc_pkg::CH_UC_A, 1'b1);

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          snd_idle = 38;
          rcv_idle = 55;
        end
        1: begin
          snd_idle = 55;
          rcv_idle = 38;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
        end
      endcase
      for (int s = 0; s < 2; s++) begin
        m = ((s ^ p) & 1) ? upc_pkg::MODE_DECODE : upc_pkg::MODE_ENCODE;
        wait_drained();
        write_mode(m);
        if (p == 2 && s == 1) hold_reqs++;
        make_batch(m, 22);
      end
    end

    wait_drained();
    if (n_bad == 0) begin
      $display("url_percent_codec test passed");
    end else begin
      $display("url_percent_codec test failed");
    end
    $finish;
  end

endmodule
